// ===== hw/rtl/sic_pkg.sv =====
// Shared relation codes and lane indexes for the segment intersection classifier.
package sic_pkg;

    // Relation between the two segments, as delivered on the relation port.
    typedef enum logic [2:0] {
        REL_COLLINEAR  = 3'd0,
        REL_PARALLEL   = 3'd1,
        REL_CROSS      = 3'd2,
        REL_AB_CUTS_CD = 3'd3,
        REL_CD_CUTS_AB = 3'd4,
        REL_LINES_ONLY = 3'd5
    } rel_t;

    // Coordinate lanes of the crossing point datapath.
    localparam int LANES  = 2;
    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;

endpackage

// ===== hw/rtl/sic_div_step.sv =====
// One restoring division step: subtracts the shifted divisor when it fits.
module sic_div_step #(
    parameter int REM_W = 100,
    parameter int DIV_W = 67,
    parameter int SHIFT = 0
) (
    input  logic [REM_W-1:0] rem,
    input  logic [DIV_W-1:0] div,
    output logic [REM_W-1:0] rem_next,
    output logic             qbit
);

    logic [REM_W-1:0] shifted;

    // Compare against the divisor aligned to this quotient bit.
    always_comb
    begin
        shifted  = REM_W'(div) << SHIFT;
        qbit     = (rem >= shifted);
        rem_next = qbit ? (rem - shifted) : rem;
    end

endmodule

// ===== hw/rtl/segment_intersection_classifier_unit.sv =====
// Top level of the two-segment intersection classifier pipeline.
// Takes segments AB and CD as signed fixed-point coordinates and returns
// one result item per input item: the relation code, the crossing point
// truncated toward zero and saturated, and its valid and clipped flags.
// The block is fully pipelined and accepts one item every cycle while
// in_stall is low. The quotient divider resolves one bit per stage over
// COORD_WIDTH + 1 stages for each coordinate. A two-entry output buffer
// lets the pipeline keep moving while one result waits; input stall rises
// only when both entries are full.
module segment_intersection_classifier_unit
    import sic_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] ax,
    input  logic signed [COORD_WIDTH-1:0] ay,
    input  logic signed [COORD_WIDTH-1:0] bx,
    input  logic signed [COORD_WIDTH-1:0] by,
    input  logic signed [COORD_WIDTH-1:0] cx,
    input  logic signed [COORD_WIDTH-1:0] cy,
    input  logic signed [COORD_WIDTH-1:0] dx,
    input  logic signed [COORD_WIDTH-1:0] dy,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    relation,
    output logic signed [COORD_WIDTH-1:0] cross_x,
    output logic signed [COORD_WIDTH-1:0] cross_y,
    output logic                          point_valid,
    output logic                          point_clipped
);

    localparam int W   = COORD_WIDTH;
    localparam int DW  = W + 1;        // coordinate difference
    localparam int PW  = 2 * W + 2;    // product of two differences
    localparam int NW  = 2 * W + 3;    // cross-product numerators and denominator
    localparam int K   = W + 2;        // low slice of N for the split multiply
    localparam int HW  = NW - K;       // high slice of N
    localparam int LW  = K + 1 + DW;   // low partial product
    localparam int HPW = HW + DW;      // high partial product
    localparam int PPW = NW + DW;      // N times segment delta
    localparam int VW  = W + 3;        // final coordinate before saturation
    localparam int DS  = W + 1;        // divider stages

    localparam logic signed [VW-1:0] TOP_V = VW'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [VW-1:0] BOT_V = -TOP_V - VW'(1);

    logic en;
    logic sk_v_reg;
    logic out_v_reg;

    assign en       = !sk_v_reg;
    assign in_stall = sk_v_reg;

    // Stage 1: register coordinates and differences.
    logic                 s1_v_reg;
    logic signed [W-1:0]  s1_a_reg [LANES];
    logic signed [DW-1:0] s1_b_reg [LANES];
    logic signed [DW-1:0] s1_acx_reg, s1_acy_reg, s1_dcx_reg, s1_dcy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_a_reg[LANE_X] <= ax;
            s1_a_reg[LANE_Y] <= ay;
            s1_b_reg[LANE_X] <= DW'(bx) - DW'(ax);
            s1_b_reg[LANE_Y] <= DW'(by) - DW'(ay);
            s1_acx_reg       <= DW'(ax) - DW'(cx);
            s1_acy_reg       <= DW'(ay) - DW'(cy);
            s1_dcx_reg       <= DW'(dx) - DW'(cx);
            s1_dcy_reg       <= DW'(dy) - DW'(cy);
        end
    end

    // Stage 2: the six cross-product terms.
    logic                 s2_v_reg;
    logic signed [W-1:0]  s2_a_reg [LANES];
    logic signed [DW-1:0] s2_b_reg [LANES];
    logic signed [PW-1:0] s2_n0_reg, s2_n1_reg, s2_m0_reg, s2_m1_reg, s2_q0_reg, s2_q1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_a_reg  <= s1_a_reg;
            s2_b_reg  <= s1_b_reg;
            s2_n0_reg <= s1_acy_reg * s1_dcx_reg;
            s2_n1_reg <= s1_acx_reg * s1_dcy_reg;
            s2_m0_reg <= s1_acy_reg * s1_b_reg[LANE_X];
            s2_m1_reg <= s1_acx_reg * s1_b_reg[LANE_Y];
            s2_q0_reg <= s1_b_reg[LANE_X] * s1_dcy_reg;
            s2_q1_reg <= s1_b_reg[LANE_Y] * s1_dcx_reg;
        end
    end

    // Stage 3: numerators N, M and denominator Q.
    logic                 s3_v_reg;
    logic signed [W-1:0]  s3_a_reg [LANES];
    logic signed [DW-1:0] s3_b_reg [LANES];
    logic signed [NW-1:0] s3_n_reg, s3_m_reg, s3_q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_a_reg <= s2_a_reg;
            s3_b_reg <= s2_b_reg;
            s3_n_reg <= NW'(s2_n0_reg) - NW'(s2_n1_reg);
            s3_m_reg <= NW'(s2_m0_reg) - NW'(s2_m1_reg);
            s3_q_reg <= NW'(s2_q0_reg) - NW'(s2_q1_reg);
        end
    end

    // Stage 4: make the denominator positive and flag zero values.
    logic                 s4_v_reg;
    logic signed [W-1:0]  s4_a_reg [LANES];
    logic signed [DW-1:0] s4_b_reg [LANES];
    logic signed [NW-1:0] s4_n_reg, s4_m_reg, s4_q_reg;
    logic                 s4_qz_reg, s4_nz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_a_reg  <= s3_a_reg;
            s4_b_reg  <= s3_b_reg;
            s4_qz_reg <= (s3_q_reg == '0);
            s4_nz_reg <= (s3_n_reg == '0);
            s4_n_reg  <= s3_q_reg[NW-1] ? -s3_n_reg : s3_n_reg;
            s4_m_reg  <= s3_q_reg[NW-1] ? -s3_m_reg : s3_m_reg;
            s4_q_reg  <= s3_q_reg[NW-1] ? -s3_q_reg : s3_q_reg;
        end
    end

    // Stage 5: classify and form the split partial products of N times delta.
    logic                  s5_v_reg;
    logic signed [W-1:0]   s5_a_reg [LANES];
    logic signed [LW-1:0]  s5_pl_reg [LANES];
    logic signed [HPW-1:0] s5_ph_reg [LANES];
    logic [NW-1:0]         s5_q_reg;
    logic                  s5_pv_reg;
    rel_t                  s5_rel_reg;
    rel_t                  s5_rel;
    logic signed [K:0]     n_lo;
    logic signed [HW-1:0]  n_hi;

    always_comb
    begin
        logic in_ab;
        logic in_cd;
        in_ab = !s4_n_reg[NW-1] && (s4_n_reg <= s4_q_reg);
        in_cd = !s4_m_reg[NW-1] && (s4_m_reg <= s4_q_reg);
        n_lo  = $signed({1'b0, s4_n_reg[K-1:0]});
        n_hi  = s4_n_reg[NW-1:K];
        if (s4_qz_reg)
        begin
            s5_rel = s4_nz_reg ? REL_COLLINEAR : REL_PARALLEL;
        end
        else if (in_ab && in_cd)
        begin
            s5_rel = REL_CROSS;
        end
        else if (in_cd)
        begin
            s5_rel = REL_AB_CUTS_CD;
        end
        else if (in_ab)
        begin
            s5_rel = REL_CD_CUTS_AB;
        end
        else
        begin
            s5_rel = REL_LINES_ONLY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s5_v_reg <= s4_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_a_reg   <= s4_a_reg;
            s5_q_reg   <= s4_q_reg;
            s5_pv_reg  <= !s4_qz_reg;
            s5_rel_reg <= s5_rel;
            for (int l = 0; l < LANES; l++)
            begin
                s5_pl_reg[l] <= n_lo * s4_b_reg[l];
                s5_ph_reg[l] <= n_hi * s4_b_reg[l];
            end
        end
    end

    // Stage 6: recombine the partial products.
    logic                  s6_v_reg;
    logic signed [W-1:0]   s6_a_reg [LANES];
    logic signed [PPW-1:0] s6_p_reg [LANES];
    logic [NW-1:0]         s6_q_reg;
    logic                  s6_pv_reg;
    rel_t                  s6_rel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s6_v_reg <= s5_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_a_reg   <= s5_a_reg;
            s6_q_reg   <= s5_q_reg;
            s6_pv_reg  <= s5_pv_reg;
            s6_rel_reg <= s5_rel_reg;
            for (int l = 0; l < LANES; l++)
            begin
                s6_p_reg[l] <= (PPW'(s5_ph_reg[l]) <<< K) + PPW'(s5_pl_reg[l]);
            end
        end
    end

    // Stage 7 feeds the divider: magnitude, sign and early overflow test.
    // A quotient of 2^(W+1) or more always lands outside the coordinate range.
    logic           dv_v_reg   [DS+1];
    logic [NW-1:0]  dv_q_reg   [DS+1];
    logic           dv_pv_reg  [DS+1];
    rel_t           dv_rel_reg [DS+1];
    logic [W-1:0]   dv_a_reg   [DS+1][LANES];
    logic           dv_s_reg   [DS+1][LANES];
    logic           dv_big_reg [DS+1][LANES];
    logic [PPW-1:0] dv_rem_reg [DS+1][LANES];
    logic [DW-1:0]  dv_quo_reg [DS+1][LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_v_reg[0] <= s6_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_q_reg[0]   <= s6_q_reg;
            dv_pv_reg[0]  <= s6_pv_reg;
            dv_rel_reg[0] <= s6_rel_reg;
            for (int l = 0; l < LANES; l++)
            begin
                logic [PPW-1:0] mag;
                mag = s6_p_reg[l][PPW-1] ? PPW'(-s6_p_reg[l]) : PPW'(s6_p_reg[l]);
                dv_a_reg[0][l]   <= s6_a_reg[l];
                dv_s_reg[0][l]   <= s6_p_reg[l][PPW-1];
                dv_big_reg[0][l] <= (mag >= (PPW'(s6_q_reg) << (W + 1)));
                dv_rem_reg[0][l] <= mag;
                dv_quo_reg[0][l] <= '0;
            end
        end
    end

    // Divider stages: one quotient bit per stage, most significant first.
    for (genvar j = 0; j < DS; j++)
    begin : g_div
        logic [PPW-1:0] step_rem [LANES];
        logic           step_bit [LANES];

        for (genvar l = 0; l < LANES; l++)
        begin : g_lane
            sic_div_step #(
                .REM_W (PPW),
                .DIV_W (NW),
                .SHIFT (W - j)
            ) u_step (
                .rem      (dv_rem_reg[j][l]),
                .div      (dv_q_reg[j]),
                .rem_next (step_rem[l]),
                .qbit     (step_bit[l])
            );
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_v_reg[j+1] <= dv_v_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_q_reg[j+1]   <= dv_q_reg[j];
                dv_pv_reg[j+1]  <= dv_pv_reg[j];
                dv_rel_reg[j+1] <= dv_rel_reg[j];
                for (int l = 0; l < LANES; l++)
                begin
                    dv_a_reg[j+1][l]   <= dv_a_reg[j][l];
                    dv_s_reg[j+1][l]   <= dv_s_reg[j][l];
                    dv_big_reg[j+1][l] <= dv_big_reg[j][l];
                    dv_rem_reg[j+1][l] <= step_rem[l];
                    dv_quo_reg[j+1][l] <= dv_quo_reg[j][l] | (DW'(step_bit[l]) << (W - j));
                end
            end
        end
    end

    // Final stage: add the start coordinate, truncate toward zero, saturate.
    logic                fs_v_reg;
    rel_t                fs_rel_reg;
    logic signed [W-1:0] fs_c_reg [LANES];
    logic                fs_pv_reg, fs_clip_reg;
    logic signed [W-1:0] fs_c [LANES];
    logic                fs_clip;

    always_comb
    begin
        fs_clip = 1'b0;
        for (int l = 0; l < LANES; l++)
        begin
            logic signed [VW-1:0] qs;
            logic signed [VW-1:0] v;
            logic                 rnz;
            qs  = $signed({2'b00, dv_quo_reg[DS][l]});
            if (dv_s_reg[DS][l])
            begin
                qs = -qs;
            end
            v   = VW'($signed(dv_a_reg[DS][l])) + qs;
            rnz = (dv_rem_reg[DS][l] != '0);
            if (rnz && !dv_s_reg[DS][l] && v[VW-1])
            begin
                v = v + VW'(1);
            end
            else if (rnz && dv_s_reg[DS][l] && !v[VW-1] && (v != '0))
            begin
                v = v - VW'(1);
            end
            if (dv_big_reg[DS][l])
            begin
                fs_c[l] = dv_s_reg[DS][l] ? BOT_V[W-1:0] : TOP_V[W-1:0];
                fs_clip = 1'b1;
            end
            else if (v > TOP_V)
            begin
                fs_c[l] = TOP_V[W-1:0];
                fs_clip = 1'b1;
            end
            else if (v < BOT_V)
            begin
                fs_c[l] = BOT_V[W-1:0];
                fs_clip = 1'b1;
            end
            else
            begin
                fs_c[l] = v[W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_v_reg <= 1'b0;
        end
        else if (en)
        begin
            fs_v_reg <= dv_v_reg[DS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fs_rel_reg  <= dv_rel_reg[DS];
            fs_pv_reg   <= dv_pv_reg[DS];
            fs_clip_reg <= dv_pv_reg[DS] && fs_clip;
            for (int l = 0; l < LANES; l++)
            begin
                fs_c_reg[l] <= dv_pv_reg[DS] ? fs_c[l] : '0;
            end
        end
    end

    // Output register with a skid entry behind it.
    rel_t                out_rel_reg, sk_rel_reg;
    logic signed [W-1:0] out_c_reg [LANES];
    logic signed [W-1:0] sk_c_reg  [LANES];
    logic                out_pv_reg, out_clip_reg, sk_pv_reg, sk_clip_reg;
    logic                take;
    logic                push;

    assign take = out_v_reg && !out_stall;
    assign push = en && fs_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
            sk_v_reg  <= 1'b0;
        end
        else
        begin
            if (sk_v_reg)
            begin
                if (take)
                begin
                    sk_v_reg <= 1'b0;
                end
            end
            else if (push)
            begin
                out_v_reg <= 1'b1;
                if (out_v_reg && !take)
                begin
                    sk_v_reg <= 1'b1;
                end
            end
            else if (take)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sk_v_reg)
        begin
            if (take)
            begin
                out_rel_reg  <= sk_rel_reg;
                out_c_reg    <= sk_c_reg;
                out_pv_reg   <= sk_pv_reg;
                out_clip_reg <= sk_clip_reg;
            end
        end
        else if (push)
        begin
            if (out_v_reg && !take)
            begin
                sk_rel_reg  <= fs_rel_reg;
                sk_c_reg    <= fs_c_reg;
                sk_pv_reg   <= fs_pv_reg;
                sk_clip_reg <= fs_clip_reg;
            end
            else
            begin
                out_rel_reg  <= fs_rel_reg;
                out_c_reg    <= fs_c_reg;
                out_pv_reg   <= fs_pv_reg;
                out_clip_reg <= fs_clip_reg;
            end
        end
    end

    assign out_valid     = out_v_reg;
    assign relation      = out_rel_reg;
    assign cross_x       = out_c_reg[LANE_X];
    assign cross_y       = out_c_reg[LANE_Y];
    assign point_valid   = out_pv_reg;
    assign point_clipped = out_clip_reg;

endmodule

// ===== hw/rtl/sic_checker.sv =====
// Port-level checks on result items of the intersection classifier, and their bind.
module sic_checker
    import sic_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [2:0]                    relation,
    input logic signed [COORD_WIDTH-1:0] cross_x,
    input logic signed [COORD_WIDTH-1:0] cross_y,
    input logic                          point_valid,
    input logic                          point_clipped
);

    localparam logic [COORD_WIDTH-1:0] MAX_C = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] MIN_C = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // A point is given exactly when the lines are not parallel or collinear.
    a_point_rel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (point_valid == (relation != REL_COLLINEAR && relation != REL_PARALLEL)))
        else $error("point_valid disagrees with relation");

    // Without a point every coordinate field is zero.
    a_no_point_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !point_valid |-> cross_x == '0 && cross_y == '0 && !point_clipped)
        else $error("fields set on an item without a crossing point");

    // A clipped point has at least one coordinate at a range end.
    a_clip_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && point_clipped |->
            (cross_x == MAX_C || cross_x == MIN_C || cross_y == MAX_C || cross_y == MIN_C))
        else $error("clipped item with no saturated coordinate");

    // A stalled result item holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(relation) && $stable(cross_x)
            && $stable(cross_y))
        else $error("stalled result item changed");

endmodule

bind segment_intersection_classifier_unit sic_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_sic_checker (.*);
